[src/resource_id_free_slot_search_unit_assert.svh]
// Assertion macros shared by the resource ID search block.
// No dependencies; the including module must provide i_clk and i_rst_n.
`ifndef RESOURCE_ID_FREE_SLOT_SEARCH_UNIT_ASSERT_SVH
`define RESOURCE_ID_FREE_SLOT_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RFSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rfss_pkg.sv]
`timescale 1ns / 1ps
// Package for the resource ID search block: widths, codes and shared types.
// No dependencies.
package rfss_pkg;

    localparam int SERIAL_BITS_DEF = 16;
    localparam int ID_W            = 32;
    localparam int TABLE_W         = 16;

    typedef enum logic [1:0] {
        FN_TO_INDEX    = 2'd0,
        FN_FIND_START  = 2'd1,
        FN_CHECK_REPLY = 2'd2,
        FN_RESERVED    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_INDEX_OK  = 3'd0,
        ST_INVALID   = 3'd1,
        ST_CANDIDATE = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NONE_FREE = 3'd4,
        ST_NO_SEARCH = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_ADV,
        S_DIV,
        S_EMIT
    } t_state;

    // Status of the shared modulo unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

endpackage

[src/rfss_mod.sv]
`timescale 1ns / 1ps
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// Depends on rfss_pkg.
module rfss_mod import rfss_pkg::*; #(
    parameter int DIVIDEND_W = SERIAL_BITS_DEF + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [TABLE_W-1:0]    i_divisor,
    output t_mod_stat             o_stat,
    output logic [TABLE_W-1:0]    o_rem
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_done, n_done;
    logic [DIVIDEND_W-1:0] r_shift, n_shift;
    logic [TABLE_W-1:0]    r_rem, n_rem;
    logic [TABLE_W:0]      w_trial;
    logic [TABLE_W:0]      w_diff;

    // The partial remainder stays below the divisor, so the trial fits one extra bit.
    assign w_trial = {r_rem, r_shift[DIVIDEND_W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_comb begin
        n_count = r_count;
        n_shift = r_shift;
        n_rem   = r_rem;
        n_done  = (r_count == CNT_W'(1)) && !i_start;
        if (i_start) begin
            n_count = CNT_W'(DIVIDEND_W);
            n_shift = i_dividend;
            n_rem   = '0;
        end else if (r_count != '0) begin
            n_count = r_count - CNT_W'(1);
            n_shift = {r_shift[DIVIDEND_W-2:0], 1'b0};
            if (w_trial >= {1'b0, i_divisor}) begin
                n_rem = w_diff[TABLE_W-1:0];
            end else begin
                n_rem = w_trial[TABLE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_rem   <= n_rem;
    end

    assign o_stat.busy = (r_count != '0);
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

[src/resource_id_free_slot_search_unit.sv]
`timescale 1ns / 1ps
// Top level of the resource ID index conversion and free-slot search block.
// Depends on rfss_pkg, rfss_mod and the assertion macro header.
//
//  channel   direction  handshake                     payload
//  input     in         i_in_valid / o_in_stall       i_func, i_resource_id, i_base_value,
//                                                     i_in_use
//  result    out        o_out_valid / i_out_stall     o_status, o_slot_index, o_id_out
//  config    in         i_cfg_valid / o_cfg_ready     i_cfg_table_size
//
// A to_index word that reaches the modulo and a search word whose serial wraps pass through
// the bit-serial modulo unit; other words skip it. One word is worked on at a time, and the
// next is taken while the previous result waits in the output register; a stalled result
// holds the block only once the next result is ready. Reset is synchronous and active low;
// it clears table_size, the search state and the handshakes.
`include "resource_id_free_slot_search_unit_assert.svh"

module resource_id_free_slot_search_unit import rfss_pkg::*; #(
    parameter int SERIAL_BITS = SERIAL_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [ID_W-1:0]    i_resource_id,
    input  logic [ID_W-1:0]    i_base_value,
    input  logic               i_in_use,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [TABLE_W-1:0] o_slot_index,
    output logic [ID_W-1:0]    o_id_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [TABLE_W-1:0] i_cfg_table_size
);

    localparam int BASE_W = ID_W - SERIAL_BITS;
    localparam int DIV_W  = SERIAL_BITS + 1;

    t_state               r_state, n_state;
    t_func                r_func, n_func;
    logic [ID_W-1:0]      r_id, n_id;
    logic [ID_W-1:0]      r_base, n_base;
    logic                 r_in_use, n_in_use;
    logic [TABLE_W-1:0]   r_table_size;
    logic [BASE_W-1:0]    r_search_base, n_search_base;
    logic [SERIAL_BITS-1:0] r_cur_serial, n_cur_serial;
    logic [TABLE_W-1:0]   r_tries_left, n_tries_left;
    logic                 r_searching, n_searching;
    t_status              r_res_status, n_res_status;
    logic [TABLE_W-1:0]   r_res_slot, n_res_slot;
    logic [ID_W-1:0]      r_res_id, n_res_id;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [TABLE_W-1:0]   r_out_slot, n_out_slot;
    logic [ID_W-1:0]      r_out_id, n_out_id;

    logic [ID_W-1:0]      w_diff;
    logic                 w_idx_bad;
    logic [DIV_W-1:0]     w_ser_inc;
    logic                 w_ser_wrap;
    logic                 w_adv_div;
    logic                 w_fin;
    logic [SERIAL_BITS-1:0] w_fin_ser;
    logic [SERIAL_BITS+TABLE_W-1:0] w_rem_ext;
    logic [ID_W-1:0]      w_cand;
    logic                 w_out_load;
    logic                 w_mod_start;
    logic [DIV_W-1:0]     w_mod_dividend;
    t_mod_stat            w_mod_stat;
    logic [TABLE_W-1:0]   w_mod_rem;

    rfss_mod #(
        .DIVIDEND_W (DIV_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dividend),
        .i_divisor  (r_table_size),
        .o_stat     (w_mod_stat),
        .o_rem      (w_mod_rem)
    );

    assign w_diff     = r_id - r_base;
    assign w_idx_bad  = (w_diff[ID_W-1:SERIAL_BITS] != '0) || (r_table_size == '0);
    assign w_ser_inc  = {1'b0, r_cur_serial} + DIV_W'(1);
    assign w_ser_wrap = (w_ser_inc >= {1'b0, {SERIAL_BITS{1'b1}}});
    // A wrapping serial goes through the modulo unit while tries remain, unless table_size is zero.
    assign w_adv_div  = (r_tries_left != '0) && w_ser_wrap && (r_table_size != '0);
    assign w_rem_ext  = {{SERIAL_BITS{1'b0}}, w_mod_rem};
    assign w_out_load = !r_out_valid || !i_out_stall;

    assign w_mod_start = ((r_state == S_EVAL) && (r_func == FN_TO_INDEX) && !w_idx_bad)
                      || ((r_state == S_ADV) && w_adv_div);
    assign w_mod_dividend = (r_state == S_EVAL) ? {1'b0, w_diff[SERIAL_BITS-1:0]} : w_ser_inc;

    // Finishing an advance: either straight from the increment (zero when it wraps) or after the modulo.
    assign w_fin = ((r_state == S_ADV) && (r_tries_left != '0) && !w_adv_div)
                || ((r_state == S_DIV) && w_mod_stat.done && (r_func != FN_TO_INDEX));
    always_comb begin
        if (r_state == S_DIV) begin
            w_fin_ser = w_rem_ext[SERIAL_BITS-1:0];
        end else if (w_ser_wrap) begin
            w_fin_ser = '0;
        end else begin
            w_fin_ser = w_ser_inc[SERIAL_BITS-1:0];
        end
    end
    assign w_cand = {r_search_base, w_fin_ser};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                case (r_func)
                    FN_TO_INDEX:    n_state = w_idx_bad ? S_EMIT : S_DIV;
                    FN_FIND_START:  n_state = S_ADV;
                    FN_CHECK_REPLY: n_state = (r_searching && r_in_use) ? S_ADV : S_EMIT;
                    default:        n_state = S_IDLE;
                endcase
            end
            S_ADV:  n_state = w_adv_div ? S_DIV : S_EMIT;
            S_DIV: begin
                if (w_mod_stat.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_func        = r_func;
        n_id          = r_id;
        n_base        = r_base;
        n_in_use      = r_in_use;
        n_search_base = r_search_base;
        n_cur_serial  = r_cur_serial;
        n_tries_left  = r_tries_left;
        n_searching   = r_searching;
        n_res_status  = r_res_status;
        n_res_slot    = r_res_slot;
        n_res_id      = r_res_id;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_status  = r_out_status;
        n_out_slot    = r_out_slot;
        n_out_id      = r_out_id;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func   = t_func'(i_func);
                    n_id     = i_resource_id;
                    n_base   = i_base_value;
                    n_in_use = i_in_use;
                end
            end
            S_EVAL: begin
                n_res_status = ST_INVALID;
                n_res_slot   = '0;
                n_res_id     = '0;
                case (r_func)
                    FN_FIND_START: begin
                        n_search_base = r_id[ID_W-1:SERIAL_BITS];
                        n_cur_serial  = r_id[SERIAL_BITS-1:0];
                        n_tries_left  = r_table_size;
                    end
                    FN_CHECK_REPLY: begin
                        if (!r_searching) begin
                            n_res_status = ST_NO_SEARCH;
                        end else if (!r_in_use) begin
                            n_searching  = 1'b0;
                            n_res_status = ST_FOUND;
                            n_res_id     = {r_search_base, r_cur_serial};
                        end
                    end
                    default: ;
                endcase
            end
            S_ADV: begin
                if (r_tries_left == '0) begin
                    n_searching  = 1'b0;
                    n_res_status = ST_NONE_FREE;
                end
            end
            S_DIV: begin
                if (w_mod_stat.done && (r_func == FN_TO_INDEX)) begin
                    n_res_status = ST_INDEX_OK;
                    n_res_slot   = w_mod_rem;
                end
            end
            S_EMIT: begin
                if (w_out_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_id     = r_res_id;
                end
            end
            default: ;
        endcase

        if (w_fin) begin
            n_tries_left = r_tries_left - TABLE_W'(1);
            if (w_cand == '0) begin
                // The zero ID means undefined, so the search ends.
                n_searching  = 1'b0;
                n_res_status = ST_NONE_FREE;
                n_res_id     = '0;
            end else begin
                n_cur_serial = w_fin_ser;
                n_searching  = 1'b1;
                n_res_status = ST_CANDIDATE;
                n_res_id     = w_cand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_table_size  <= '0;
            r_search_base <= '0;
            r_cur_serial  <= '0;
            r_tries_left  <= '0;
            r_searching   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_search_base <= n_search_base;
            r_cur_serial  <= n_cur_serial;
            r_tries_left  <= n_tries_left;
            r_searching   <= n_searching;
            r_out_valid   <= n_out_valid;
            if (i_cfg_valid) begin
                r_table_size <= i_cfg_table_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_id         <= n_id;
        r_base       <= n_base;
        r_in_use     <= n_in_use;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_id     <= n_res_id;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_id     <= n_out_id;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot_index = r_out_slot;
    assign o_id_out     = r_out_id;

    `RFSS_ASSERT_IMP(a_cand_nonzero, o_out_valid && (r_out_status == ST_CANDIDATE),
        o_id_out != '0, "candidate word carries the zero ID")
    `RFSS_ASSERT_IMP(a_no_id_fields_zero,
        o_out_valid && ((r_out_status == ST_INVALID) || (r_out_status == ST_NONE_FREE)
        || (r_out_status == ST_NO_SEARCH)),
        (o_id_out == '0) && (o_slot_index == '0), "failure word carries non-zero fields")
    `RFSS_ASSERT_IMP(a_mod_only_in_div, w_mod_stat.busy || w_mod_stat.done,
        r_state == S_DIV, "modulo unit active outside its state")
    `RFSS_ASSERT_IMP(a_rem_below_size, w_mod_stat.done,
        w_mod_rem < r_table_size, "modulo remainder not below table size")
    `RFSS_ASSERT_NXT(a_div_started, w_mod_start,
        w_mod_stat.busy && (r_state == S_DIV), "modulo unit did not start")

endmodule
